// ===== design/scss_pkg.sv =====
// ----------------------------------------------------------------------------
// scss_pkg
// Shared types, codes and helpers for the scatter step slice scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package scss_pkg;

    localparam int MAX_RANKS   = 64;
    localparam int RANK_W      = 7;
    localparam int POS_W       = 6;
    localparam int STEP_W      = 3;
    localparam int SCNT_W      = 3;
    localparam int TOTAL_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        ACT_IDLE = 2'd0,
        ACT_SEND = 2'd1,
        ACT_RECV = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK_COUNT    = 2'd0,
        CFG_STEP_COUNT    = 2'd1,
        CFG_OWN_POSITION  = 2'd2,
        CFG_ROOT_POSITION = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ITER,
        F_CALC,
        F_DECIDE
    } front_state_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank_count;
        logic [SCNT_W-1:0] step_count;
        logic [POS_W-1:0]  own_position;
        logic [POS_W-1:0]  root_position;
    } cfg_t;

    typedef struct packed {
        action_t            action;
        logic [POS_W-1:0]   partner;
        logic [POS_W-1:0]   first_index;
        logic [TOTAL_W-1:0] total;
        logic [POS_W-1:0]   stride;
        logic [RANK_W-1:0]  ranks;
    } cmd_t;

    // one restoring-remainder step: shift in a bit, subtract the modulus if it fits
    function automatic logic [POS_W-1:0] rem_step(input logic [POS_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [RANK_W-1:0] r);
        logic [RANK_W-1:0] t;
        t = {rem, bit_in};
        if (t >= r) begin
            rem_step = POS_W'(t - r);
        end else begin
            rem_step = POS_W'(t);
        end
    endfunction

    // fold a value below twice the modulus back into range
    function automatic logic [POS_W-1:0] wrap_once(input logic [7:0] t,
                                                   input logic [RANK_W-1:0] r);
        if (t >= {1'b0, r}) begin
            wrap_once = POS_W'(t - {1'b0, r});
        end else begin
            wrap_once = POS_W'(t);
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/scatter_step_slice_schedule.sv =====
// ----------------------------------------------------------------------------
// scatter_step_slice_schedule
// One rank's role in one step of a halving-distance scatter: send, receive
// or idle, with the partner position and one result per moved slice.
//
//   channel   dir  handshake            payload
//   s_        in   s_tvalid/s_tready    s_tdata[2:0] step
//   m_        out  m_tvalid/m_tready    m_tdata partner/slice/total, m_tuser
//                                       action, m_tlast last
//   cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// the front takes a step in its accepting state, then runs 8 remainder/doubling
// iterations, a calc state and a decide state that pushes into the queue, and
// takes no new step until that push; the back loads a command and then emits
// one result per cycle while m_tready is high (1 to 32 results per command)
// reset is synchronous; the queue holds two commands so the front keeps
// classifying while m_tready is low
// ----------------------------------------------------------------------------
`default_nettype none

module scatter_step_slice_schedule (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [scss_pkg::S_TDATA_W-1:0]    s_tdata,   // [2:0] step
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [scss_pkg::M_TDATA_W-1:0]         m_tdata,   // [5:0] partner_position,
                                                              // [11:6] slice_index,
                                                              // [17:12] slice_total
    output logic [1:0]                             m_tuser,   // [1:0] action
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [scss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [scss_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import scss_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push, full, pop, pop_valid;
    cmd_t push_cmd, pop_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_RANK_COUNT:    cfg_next.rank_count    = cfg_data[RANK_W-1:0];
                CFG_STEP_COUNT:    cfg_next.step_count    = cfg_data[SCNT_W-1:0];
                CFG_OWN_POSITION:  cfg_next.own_position  = cfg_data[POS_W-1:0];
                CFG_ROOT_POSITION: cfg_next.root_position = cfg_data[POS_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rank_count    <= RANK_W'(MAX_RANKS);
            cfg_reg.step_count    <= SCNT_W'(6);
            cfg_reg.own_position  <= '0;
            cfg_reg.root_position <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    scss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_step   (s_tdata[STEP_W-1:0]),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    scss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid)
    );

    scss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== design/scss_fifo.sv =====
// ----------------------------------------------------------------------------
// scss_fifo
// Short command queue between the classifier front and the emitter back.
// ----------------------------------------------------------------------------
`default_nettype none

module scss_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  scss_pkg::cmd_t     push_cmd,
    output logic               full,
    input  wire logic          pop,
    output scss_pkg::cmd_t     pop_cmd,
    output logic               pop_valid
);
    import scss_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/scss_front.sv =====
// ----------------------------------------------------------------------------
// scss_front
// Takes a step number, reduces positions and distances modulo the rank
// count bit by bit, and classifies the step as send, receive or idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scss_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  scss_pkg::cfg_t                    cfg,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [scss_pkg::STEP_W-1:0]  s_step,
    output logic                              push,
    output scss_pkg::cmd_t                    push_cmd,
    input  wire logic                         full
);
    import scss_pkg::*;

    front_state_t      state_reg, state_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RANK_W-1:0] r_reg, r_next;
    logic [POS_W-1:0]  own_reg, own_next;
    logic [POS_W-1:0]  root_reg, root_next;
    logic [POS_W-1:0]  dm_reg, dm_next;
    logic [POS_W-1:0]  ds_reg, ds_next;
    logic [POS_W-1:0]  delta_reg, delta_next;
    logic [7:0]        d_reg, d_next;
    logic [TOTAL_W-1:0] nsl_reg, nsl_next;
    logic [7:0]        nranks_reg, nranks_next;

    logic [RANK_W-1:0] r_eff;
    logic [7:0]        own_ext, root_ext;
    logic [8:0]        slice_sum;
    logic [7:0]        d_val;
    logic              perfect, last_step;
    logic              is_send, is_recv;
    logic [8:0]        recv_bound;

    always_comb begin
        if (cfg.rank_count == '0) begin
            r_eff = RANK_W'(1);
        end else if (cfg.rank_count > RANK_W'(MAX_RANKS)) begin
            r_eff = RANK_W'(MAX_RANKS);
        end else begin
            r_eff = cfg.rank_count;
        end
    end

    assign own_ext  = {2'b00, cfg.own_position};
    assign root_ext = {2'b00, cfg.root_position};
    assign s_tready = (state_reg == F_IDLE);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        r_next      = r_reg;
        own_next    = own_reg;
        root_next   = root_reg;
        dm_next     = dm_reg;
        ds_next     = ds_reg;
        delta_next  = delta_reg;
        d_next      = d_reg;
        nsl_next    = nsl_reg;
        nranks_next = nranks_reg;
        push        = 1'b0;

        d_val      = 8'(1) << step_reg;
        slice_sum  = 9'(r_reg) - 9'd1 + 9'(d_val);
        perfect    = ((r_reg & (r_reg - 1'b1)) == '0);
        last_step  = ({1'b0, step_reg} + 4'd1) == {1'b0, cfg.step_count};
        is_send    = {2'b00, delta_reg} < nranks_reg;
        recv_bound = {1'b0, nranks_reg} + {1'b0, d_reg};
        is_recv    = ({2'b00, delta_reg} >= d_reg) && ({3'b000, delta_reg} < recv_bound);

        push_cmd.ranks  = r_reg;
        push_cmd.stride = ds_reg;
        push_cmd.total  = nsl_reg;
        if (is_send) begin
            push_cmd.action      = ACT_SEND;
            push_cmd.partner     = wrap_once(8'(own_reg) + 8'(r_reg) - 8'(dm_reg), r_reg);
            push_cmd.first_index = push_cmd.partner;
        end else begin
            push_cmd.action      = ACT_RECV;
            push_cmd.partner     = wrap_once(8'(own_reg) + 8'(dm_reg), r_reg);
            push_cmd.first_index = own_reg;
        end
        if ((!is_send && !is_recv) || nsl_reg == '0) begin
            push_cmd.action      = ACT_IDLE;
            push_cmd.partner     = '0;
            push_cmd.first_index = '0;
            push_cmd.total       = '0;
        end

        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    step_next  = s_step;
                    r_next     = r_eff;
                    own_next   = '0;
                    root_next  = '0;
                    dm_next    = (r_eff == RANK_W'(1)) ? POS_W'(0) : POS_W'(1);
                    ds_next    = (r_eff <= RANK_W'(2)) ? POS_W'(0) : POS_W'(2);
                    cnt_next   = '0;
                    state_next = F_ITER;
                end
            end
            F_ITER: begin
                own_next  = rem_step(own_reg, own_ext[~cnt_reg], r_reg);
                root_next = rem_step(root_reg, root_ext[~cnt_reg], r_reg);
                if (cnt_reg < step_reg) begin
                    dm_next = rem_step(dm_reg, 1'b0, r_reg);
                    ds_next = rem_step(ds_reg, 1'b0, r_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd7) begin
                    state_next = F_CALC;
                end
            end
            F_CALC: begin
                delta_next = wrap_once(8'(root_reg) + 8'(r_reg) - 8'(own_reg), r_reg);
                d_next     = d_val;
                nsl_next   = TOTAL_W'(slice_sum >> ({1'b0, step_reg} + 4'd1));
                if (!perfect && last_step) begin
                    nranks_next = ({1'b0, r_reg} > d_val) ? 8'(r_reg) - d_val : 8'd0;
                end else begin
                    nranks_next = d_val;
                end
                state_next = F_DECIDE;
            end
            F_DECIDE: begin
                if (!full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        r_reg      <= r_next;
        own_reg    <= own_next;
        root_reg   <= root_next;
        dm_reg     <= dm_next;
        ds_reg     <= ds_next;
        delta_reg  <= delta_next;
        d_reg      <= d_next;
        nsl_reg    <= nsl_next;
        nranks_reg <= nranks_next;
    end

endmodule

`default_nettype wire

// ===== design/scss_back.sv =====
// ----------------------------------------------------------------------------
// scss_back
// Emits one result per moved slice per queued command, or one for an idle one,
// stepping the slice index back by the stride modulo the rank count.
// ----------------------------------------------------------------------------
`default_nettype none

module scss_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  scss_pkg::cmd_t                     pop_cmd,
    input  wire logic                          pop_valid,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [scss_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);
    import scss_pkg::*;

    cmd_t               cmd_reg, cmd_next;
    logic               busy_reg, busy_next;
    logic [TOTAL_W-1:0] left_reg, left_next;
    logic [POS_W-1:0]   idx_reg, idx_next;
    logic               valid_reg, valid_next;
    action_t            act_reg, act_next;
    logic [POS_W-1:0]   partner_reg, partner_next;
    logic [POS_W-1:0]   slice_reg, slice_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               last_reg, last_next;
    logic               out_free;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = act_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'b000000, total_reg, slice_reg, partner_reg};

    always_comb begin
        cmd_next     = cmd_reg;
        busy_next    = busy_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        act_next     = act_reg;
        partner_next = partner_reg;
        slice_next   = slice_reg;
        total_next   = total_reg;
        last_next    = last_reg;
        pop          = 1'b0;

        if (out_free) begin
            valid_next = 1'b0;
        end

        if (busy_reg) begin
            if (out_free) begin
                valid_next   = 1'b1;
                act_next     = cmd_reg.action;
                partner_next = cmd_reg.partner;
                slice_next   = idx_reg;
                total_next   = cmd_reg.total;
                last_next    = (left_reg == TOTAL_W'(1));
                idx_next     = wrap_once(8'(idx_reg) + 8'(cmd_reg.ranks) - 8'(cmd_reg.stride),
                                         cmd_reg.ranks);
                left_next    = left_reg - 1'b1;
                if (left_reg == TOTAL_W'(1)) begin
                    busy_next = 1'b0;
                end
            end
        end else if (pop_valid) begin
            pop       = 1'b1;
            cmd_next  = pop_cmd;
            busy_next = 1'b1;
            idx_next  = pop_cmd.first_index;
            left_next = (pop_cmd.total == '0) ? TOTAL_W'(1) : pop_cmd.total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        act_reg     <= act_next;
        partner_reg <= partner_next;
        slice_reg   <= slice_next;
        total_reg   <= total_next;
        last_reg    <= last_next;
    end

endmodule

`default_nettype wire

// ===== design/scss_checker.sv =====
// ----------------------------------------------------------------------------
// scss_checker
// Port-level checks on the result stream of the scatter step scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module scss_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [scss_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [1:0]                        m_tuser,
    input wire logic                              m_tlast
);
    import scss_pkg::*;

    // a stalled transfer keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // idle steps carry a single all-zero result
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ACT_IDLE |-> m_tlast && m_tdata == '0)
        else $error("idle result not clean");

    // active results move between one and 32 slices and never use the spare code
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ACT_IDLE |->
            (m_tuser == ACT_SEND || m_tuser == ACT_RECV)
            && m_tdata[17:12] != '0 && m_tdata[17:12] <= 6'd32)
        else $error("bad action or slice total");

    // within a step the action and partner stay fixed
    a_same_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
            m_tuser == $past(m_tuser) && m_tdata[5:0] == $past(m_tdata[5:0]))
        else $error("partner changed inside a step");

    a_reset: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind scatter_step_slice_schedule scss_checker u_scss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
